// ===== sv/msb_first_bit_field_reader_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MBR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/mbr_pkg.sv =====
// ---------------------------------------------------------------------------
// Bit field reader package
// Operation codes, state encoding and status bit positions.
// ---------------------------------------------------------------------------
package mbr_pkg;
  typedef enum logic [3:0] {
    FN_LOAD = 4'd0, FN_READ = 4'd1, FN_GET = 4'd2, FN_PEEK = 4'd3,
    FN_SKIP = 4'd4, FN_SEEKA = 4'd5, FN_SEEKR = 4'd6, FN_ALIGN = 4'd7,
    FN_UNGET = 4'd8, FN_CLEAR = 4'd9, FN_SETST = 4'd10, FN_EXPECT = 4'd11,
    FN_QUERY = 4'd12, FN_RSV13 = 4'd13, FN_RSV14 = 4'd14, FN_RSV15 = 4'd15
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_WAIT, S_SHIFT, S_DIV, S_DONE
  } state_t;

  localparam logic [2:0] ST_BAD  = 3'b001;
  localparam logic [2:0] ST_FAIL = 3'b010;
  localparam logic [2:0] ST_EOF  = 3'b100;

  localparam logic [1:0] DIR_START = 2'd0;
  localparam logic [1:0] DIR_CUR   = 2'd1;
  localparam logic [1:0] DIR_END   = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
endpackage

// ===== sv/msb_first_bit_field_reader_top.sv =====
// ---------------------------------------------------------------------------
// MSB-first bit field reader
// Byte buffer with a bounded bit read pointer and a status register.
// ---------------------------------------------------------------------------
// Usage: one word on the in_ channel carries an operation (in_func) and its
// operands; every accepted word yields exactly one word on the out_ channel
// with the last value, last count, position and status. Bytes are loaded with
// the load operation and read back as MSB-first fields of up to
// MAX_FIELD_BITS bits. The region registers are written over the cfg_ port.
// A word that needs no buffer read and no division shows its result in the
// cycle after acceptance. A field read fetches one byte per pass, each pass
// going through address, registered data and merge, until every byte the
// field touches is merged; a 64-bit field that starts mid-byte touches nine
// bytes. Align runs a 16-step restoring division of (position + width - 1)
// by the width, one quotient bit per cycle.
// One word is in work at a time; in_stall is high from acceptance until the
// result has been taken. While out_stall is high the result holds. Reset
// clears position, status, last value and count and sets the region to
// 0..32768; buffer contents stay undefined until loaded.
// ---------------------------------------------------------------------------
module msb_first_bit_field_reader_top
  import mbr_pkg::*;
#(
  parameter int BUF_BYTES      = 4096,
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic [6:0]  in_width,
  input  logic [15:0] in_skip_count,
  input  logic signed [16:0] in_offset,
  input  logic [1:0]  in_base_sel,
  input  logic [11:0] in_byte_addr,
  input  logic [7:0]  in_byte_data,
  input  logic [2:0]  in_status_bits,
  input  logic        in_expected_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic [15:0] out_count,
  output logic [15:0] out_position,
  output logic [2:0]  out_status,
  output logic        out_good,
  output logic        out_failed,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  // Buffer memory.
  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_data_r;
  logic       mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // Architectural state.
  logic [15:0] rstart_r, rend_r, pos_r, cnt_r;
  logic [2:0]  st_r;
  logic [63:0] val_r;

  // Work registers.
  state_t      state_r, state_nxt;
  func_t       fn_r;
  logic [6:0]  w_r;
  logic        exp_r;
  logic [16:0] bpos_r, bpos_nxt;   // bit cursor into the buffer
  logic [6:0]  left_r, left_nxt;   // bits still to take
  logic [63:0] acc_r, acc_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [15:0] dvd_r;
  logic        start_go;

  assign cfg_pready = 1'b1;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign start_go   = in_valid && (state_r == S_IDLE);
  assign out_value    = val_r;
  assign out_count    = cnt_r;
  assign out_position = pos_r;
  assign out_status   = st_r;
  assign out_good     = (st_r == 3'b000);
  assign out_failed   = st_r[1] | st_r[2];

  always_comb begin
    unique case (cfg_paddr[2])
      REG_START[0]: cfg_prdata = {16'd0, rstart_r};
      default:      cfg_prdata = {16'd0, rend_r};
    endcase
  end

  // Memory write and registered read.
  assign mem_we    = start_go && (in_func == FN_LOAD) &&
                     ({5'd0, in_byte_addr} < 17'(BUF_BYTES));
  assign mem_waddr = AW'(in_byte_addr);
  assign mem_raddr = AW'(bpos_r[16:3]);
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_byte_data;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Read feasibility and move target, evaluated at acceptance.
  logic [6:0]  rw;
  logic        rd_ok;
  logic signed [17:0] avail;
  logic signed [17:0] tgt;
  logic        tgt_ok, dir_bad;
  logic        byte_in_buf;
  logic [3:0]  boff;
  logic [7:0]  shifted;
  logic [3:0]  take;
  logic [63:0] mask_acc;

  always_comb begin
    unique case (func_t'(in_func))
      FN_GET, FN_PEEK, FN_EXPECT: rw = 7'd1;
      default:                    rw = in_width;
    endcase
    avail = $signed({2'b0, rend_r}) - $signed({2'b0, pos_r});
    rd_ok = (rw <= 7'(MAX_FIELD_BITS)) && ($signed({11'd0, rw}) <= avail);
    dir_bad = 1'b0;
    unique case (func_t'(in_func))
      FN_SKIP:  tgt = $signed({2'b0, pos_r}) + $signed({2'b0, in_skip_count});
      FN_SEEKA: tgt = 18'(in_offset);
      FN_UNGET: tgt = $signed({2'b0, pos_r}) - 18'sd1;
      FN_SEEKR: begin
        unique case (in_base_sel)
          DIR_START: tgt = $signed({2'b0, rstart_r}) + 18'(in_offset);
          DIR_CUR:   tgt = $signed({2'b0, pos_r}) + 18'(in_offset);
          DIR_END:   tgt = $signed({2'b0, rend_r}) + 18'(in_offset);
          default: begin
            tgt = 18'sd0;
            dir_bad = 1'b1;
          end
        endcase
      end
      default:  tgt = 18'sd0;
    endcase
    tgt_ok = !dir_bad && (tgt >= $signed({2'b0, rstart_r})) &&
             (tgt <= $signed({2'b0, rend_r}));
  end

  // Byte step of the shared extractor: take bits from the fetched byte.
  always_comb begin
    byte_in_buf = ({3'd0, bpos_r[16:3]} < 17'(BUF_BYTES));
    boff    = {1'b0, bpos_r[2:0]};
    shifted = (byte_in_buf ? rd_data_r : 8'd0) << boff[2:0];
    take    = ({1'b0, left_r} < 8'(4'd8 - boff)) ? left_r[3:0] : 4'(4'd8 - boff);
    mask_acc = acc_r << take;
    mask_acc = mask_acc | 64'(shifted >> (4'd8 - take));
  end

  // Sequencer.
  logic [16:0] sub;
  always_comb begin
    state_nxt = state_r;
    bpos_nxt  = bpos_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    sub       = {rem_r[15:0], dvd_r[15]} - {10'd0, w_r};
    unique case (state_r)
      S_IDLE: begin
        bpos_nxt = {1'b0, pos_r};
        acc_nxt  = 64'd0;
        left_nxt = rw;
        rem_nxt  = 17'd0;
        quo_nxt  = 16'd0;
        step_nxt = 5'd0;
        if (in_valid) begin
          state_nxt = S_DONE;
          unique case (func_t'(in_func))
            FN_READ, FN_GET, FN_PEEK, FN_EXPECT:
              if (rd_ok && rw != 7'd0) state_nxt = S_FETCH;
            FN_ALIGN:
              if (st_r == 3'b000 && in_width != 7'd0) state_nxt = S_DIV;
            default: ;
          endcase
        end
      end
      S_FETCH: state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_SHIFT;
      S_SHIFT: begin
        acc_nxt  = mask_acc;
        left_nxt = left_r - 7'(take);
        bpos_nxt = bpos_r + 17'(take);
        state_nxt = (left_r == 7'(take)) ? S_DONE : S_FETCH;
      end
      S_DIV: begin
        // One quotient bit per cycle of (pos + w - 1) / w.
        if (!sub[16]) begin
          rem_nxt = sub;
          quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[15:0], dvd_r[15]};
          quo_nxt = {quo_r[14:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd15) state_nxt = S_DONE;
      end
      default: if (!out_stall) state_nxt = S_IDLE;
    endcase
  end

  // Align target from the quotient.
  logic [22:0] atgt;
  assign atgt = 23'(quo_nxt) * 23'(w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rstart_r <= 16'd0;
      rend_r   <= 16'd32768;
      pos_r    <= 16'd0;
      st_r     <= 3'b000;
      cnt_r    <= 16'd0;
      val_r    <= 64'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == REG_START[0]) begin
          rstart_r <= cfg_pwdata[15:0];
          pos_r    <= cfg_pwdata[15:0];
        end else begin
          rend_r <= cfg_pwdata[15:0];
        end
      end
      // Work done at acceptance.
      if (start_go) begin
        unique case (func_t'(in_func))
          FN_READ, FN_GET, FN_EXPECT: begin
            if (!rd_ok) begin
              st_r  <= st_r | ST_FAIL | ST_EOF |
                       ((func_t'(in_func) == FN_EXPECT && in_expected_bit) ?
                        ST_BAD : 3'b000);
              val_r <= 64'd0;
              cnt_r <= 16'd0;
            end else if (rw == 7'd0) begin
              val_r <= 64'd0;
              cnt_r <= 16'd0;
            end
          end
          FN_PEEK: if (!rd_ok) begin
            st_r  <= st_r | ST_EOF;
            val_r <= 64'd0;
            cnt_r <= 16'd0;
          end
          FN_SKIP: begin
            if (tgt_ok) begin
              pos_r <= tgt[15:0];
              cnt_r <= in_skip_count;
            end else begin
              st_r  <= st_r | ST_EOF;
              cnt_r <= 16'd0;
            end
          end
          FN_SEEKA, FN_SEEKR, FN_UNGET: begin
            if (tgt_ok) pos_r <= tgt[15:0];
            else st_r <= st_r | ST_FAIL;
            if (func_t'(in_func) == FN_UNGET) cnt_r <= 16'd0;
          end
          FN_ALIGN: cnt_r <= 16'd0;
          FN_CLEAR: st_r <= in_status_bits;
          FN_SETST: st_r <= st_r | in_status_bits;
          default: ;
        endcase
      end
      // Completion of a field read.
      if (state_r == S_SHIFT && state_nxt == S_DONE) begin
        val_r <= mask_acc;
        cnt_r <= {9'd0, w_r};
        if (fn_r != FN_PEEK) pos_r <= pos_r + {9'd0, w_r};
        if (fn_r == FN_EXPECT && mask_acc[0] != exp_r) st_r <= st_r | ST_BAD;
      end
      // Completion of align.
      if (state_r == S_DIV && state_nxt == S_DONE) begin
        if (atgt >= {7'd0, rstart_r} && atgt <= {7'd0, rend_r}) pos_r <= atgt[15:0];
        else st_r <= st_r | ST_FAIL;
      end
    end
  end

  // Operand and work registers, no reset needed.
  always_ff @(posedge clk) begin
    if (start_go) begin
      fn_r  <= func_t'(in_func);
      w_r   <= (func_t'(in_func) == FN_READ || func_t'(in_func) == FN_ALIGN) ?
               in_width : 7'd1;
      exp_r <= in_expected_bit;
      dvd_r <= 16'(pos_r + {9'd0, in_width} - 16'd1);
    end else if (state_r == S_DIV) begin
      dvd_r <= {dvd_r[14:0], 1'b0};
    end
    bpos_r <= bpos_nxt;
    left_r <= left_nxt;
    acc_r  <= acc_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end
endmodule

// ===== sv/mbr_checker.sv =====
// ---------------------------------------------------------------------------
// Bit field reader port checker
// Watches the top level's ports and checks the result word rules.
// ---------------------------------------------------------------------------
`include "msb_first_bit_field_reader_top_macros.svh"
module mbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_value,
  input logic [2:0]  out_status,
  input logic        out_good,
  input logic        out_failed
);
  // A held result keeps its value.
  `MBR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_value), "result changed while stalled")
  // The good flag mirrors the status.
  `MBR_ASSERT_IMP(a_good, out_valid, out_good == (out_status == 3'b000), "good flag wrong")
  // The failed flag mirrors fail or eof.
  `MBR_ASSERT_IMP(a_fail, out_valid, out_failed == (out_status[1] | out_status[2]), "failed flag wrong")
  // No new word is taken while a result is shown.
  `MBR_ASSERT_IMP(a_busy, out_valid, in_stall, "input open during result")
endmodule

bind msb_first_bit_field_reader_top mbr_checker u_mbr_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
  .out_status(out_status), .out_good(out_good), .out_failed(out_failed)
);

// ===== sim/msb_first_bit_field_reader_top_test.sv =====
// ---------------------------------------------------------------------------
// Bit field reader testbench
// Drives operation words into the reader, predicts every result word from a
// behavioural copy of the reader state and compares the two field by field,
// under random idling on both channels and several region settings.
// ---------------------------------------------------------------------------
module msb_first_bit_field_reader_top_test;
  import mbr_pkg::*;

  localparam int NUM_BYTES  = 4096;
  localparam int MAX_BITS   = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic [3:0]         func;
    logic [6:0]         width;
    logic [15:0]        skip_count;
    logic signed [16:0] offset;
    logic [1:0]         base_sel;
    logic [11:0]        byte_addr;
    logic [7:0]         byte_data;
    logic [2:0]         status_bits;
    logic               expected_bit;
  } op_word_t;

  typedef struct {
    logic [63:0] value;
    logic [15:0] count;
    logic [15:0] position;
    logic [2:0]  status;
    logic        good;
    logic        failed;
  } reader_view_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [3:0] in_func;
  logic [6:0] in_width;
  logic [15:0] in_skip_count;
  logic signed [16:0] in_offset;
  logic [1:0] in_base_sel;
  logic [11:0] in_byte_addr;
  logic [7:0] in_byte_data;
  logic [2:0] in_status_bits;
  logic in_expected_bit;
  logic out_valid, out_stall;
  logic [63:0] out_value;
  logic [15:0] out_count, out_position;
  logic [2:0] out_status;
  logic out_good, out_failed;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  msb_first_bit_field_reader_top i_dut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the reader state.
  logic [7:0] shadow_mem [NUM_BYTES];
  bit         shadow_written [NUM_BYTES];
  int         shadow_start, shadow_end, shadow_pos, shadow_count;
  logic [2:0] shadow_status;
  logic [63:0] shadow_value;

  reader_view_t pending_views [$];
  int errors;
  int send_pct, recv_pct;
  int hold_requests, hold_served, hold_left;

  function automatic logic bit_of(int p);
    if ((p >> 3) >= NUM_BYTES) return 1'b0;
    return shadow_mem[p >> 3][7 - (p & 7)];
  endfunction

  function automatic bit field_at(int wd, bit advance, output logic [63:0] v);
    v = '0;
    if (wd > MAX_BITS || wd > shadow_end - shadow_pos) return 1'b0;
    for (int i = 0; i < wd; i++) v = {v[62:0], bit_of(shadow_pos + i)};
    if (advance) shadow_pos += wd;
    return 1'b1;
  endfunction

  function automatic bit move_to(int target);
    if (target < shadow_start || target > shadow_end) return 1'b0;
    shadow_pos = target;
    return 1'b1;
  endfunction

  function automatic void consume_field(int wd);
    logic [63:0] v;
    if (field_at(wd, 1'b1, v)) begin
      shadow_value = v;
      shadow_count = wd;
    end else begin
      shadow_status |= ST_FAIL | ST_EOF;
      shadow_value = '0;
      shadow_count = 0;
    end
  endfunction

  // Applies one word to the shadow state and returns the view it leads to.
  function automatic reader_view_t apply_word(op_word_t w);
    reader_view_t r;
    logic [63:0] v;
    int off, base, t;
    off = w.offset;
    case (func_t'(w.func))
      FN_LOAD: begin
        shadow_mem[w.byte_addr] = w.byte_data;
        shadow_written[w.byte_addr] = 1'b1;
      end
      FN_READ: consume_field(int'(w.width));
      FN_GET: consume_field(1);
      FN_PEEK: begin
        if (field_at(1, 1'b0, v)) begin
          shadow_value = v;
          shadow_count = 1;
        end else begin
          shadow_status |= ST_EOF;
          shadow_value = '0;
          shadow_count = 0;
        end
      end
      FN_SKIP: begin
        if (move_to(shadow_pos + int'(w.skip_count))) shadow_count = int'(w.skip_count);
        else begin
          shadow_status |= ST_EOF;
          shadow_count = 0;
        end
      end
      FN_SEEKA: if (!move_to(off)) shadow_status |= ST_FAIL;
      FN_SEEKR: begin
        if (w.base_sel == DIR_START || w.base_sel == DIR_CUR || w.base_sel == DIR_END) begin
          base = (w.base_sel == DIR_START) ? shadow_start :
                 (w.base_sel == DIR_CUR) ? shadow_pos : shadow_end;
          if (!move_to(base + off)) shadow_status |= ST_FAIL;
        end else begin
          shadow_status |= ST_FAIL;
        end
      end
      FN_ALIGN: begin
        if (shadow_status == 3'b000 && w.width != 0) begin
          t = ((shadow_pos + int'(w.width) - 1) / int'(w.width)) * int'(w.width);
          if (!move_to(t)) shadow_status |= ST_FAIL;
        end
        shadow_count = 0;
      end
      FN_UNGET: begin
        shadow_count = 0;
        if (!move_to(shadow_pos - 1)) shadow_status |= ST_FAIL;
      end
      FN_CLEAR: shadow_status = w.status_bits;
      FN_SETST: shadow_status |= w.status_bits;
      FN_EXPECT: begin
        consume_field(1);
        if (shadow_value[0] != w.expected_bit) shadow_status |= ST_BAD;
      end
      default: ;
    endcase
    r.value    = shadow_value;
    r.count    = shadow_count[15:0];
    r.position = shadow_pos[15:0];
    r.status   = shadow_status;
    r.good     = (shadow_status == 3'b000);
    r.failed   = (shadow_status & (ST_FAIL | ST_EOF)) != 3'b000;
    return r;
  endfunction

  // Byte that a successful read would touch before it was ever loaded, or -1.
  function automatic int unloaded_byte(op_word_t w);
    int wd;
    case (func_t'(w.func))
      FN_READ: wd = int'(w.width);
      FN_GET, FN_PEEK, FN_EXPECT: wd = 1;
      default: wd = 0;
    endcase
    if (wd == 0 || wd > MAX_BITS || wd > shadow_end - shadow_pos) return -1;
    for (int i = shadow_pos >> 3; i <= (shadow_pos + wd - 1) >> 3; i++)
      if (i < NUM_BYTES && !shadow_written[i]) return i;
    return -1;
  endfunction

  function automatic op_word_t blank_word(func_t f);
    op_word_t w;
    w.func = f;
    w.width = 7'($urandom);
    w.skip_count = 16'($urandom);
    w.offset = 17'($urandom);
    w.base_sel = 2'($urandom);
    w.byte_addr = 12'($urandom);
    w.byte_data = 8'($urandom);
    w.status_bits = 3'($urandom);
    w.expected_bit = 1'($urandom);
    return w;
  endfunction

  // Random word, weighted so that most fields land near the read position.
  function automatic op_word_t random_word();
    op_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w = blank_word(pick < 15 ? FN_LOAD : pick < 40 ? FN_READ : pick < 48 ? FN_GET :
                   pick < 54 ? FN_PEEK : pick < 62 ? FN_SKIP : pick < 68 ? FN_SEEKA :
                   pick < 76 ? FN_SEEKR : pick < 82 ? FN_ALIGN : pick < 87 ? FN_UNGET :
                   pick < 93 ? FN_CLEAR : pick < 95 ? FN_SETST : pick < 98 ? FN_EXPECT :
                   func_t'($urandom_range(12, 15)));
    if ($urandom_range(0, 9) != 0) begin
      w.width = (w.func == FN_ALIGN) ? 7'($urandom_range(0, 17)) :
                7'($urandom_range(0, 64));
      w.skip_count = 16'($urandom_range(0, 40));
      w.base_sel = 2'($urandom_range(0, 2));
      w.offset = (w.func == FN_SEEKA) ?
                 17'(shadow_start + int'($urandom_range(0, 300)) - 20) :
                 17'(int'($urandom_range(0, 80)) - 40);
      w.byte_addr = 12'(((shadow_pos >> 3) + int'($urandom_range(0, 15))) % NUM_BYTES);
      if (w.func == FN_CLEAR && $urandom_range(0, 3) != 0) w.status_bits = 3'b000;
    end
    return w;
  endfunction

  // Sends one word; a read of never-loaded bytes is turned into a load of them.
  task automatic send_word(input op_word_t w);
    int gap, idx;
    idx = unloaded_byte(w);
    if (idx >= 0) begin
      w.func = FN_LOAD;
      w.byte_addr = 12'(idx);
    end
    gap = ($urandom_range(0, 99) < send_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= w.func;
    in_width <= w.width;
    in_skip_count <= w.skip_count;
    in_offset <= w.offset;
    in_base_sel <= w.base_sel;
    in_byte_addr <= w.byte_addr;
    in_byte_data <= w.byte_data;
    in_status_bits <= w.status_bits;
    in_expected_bit <= w.expected_bit;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(apply_word(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // Region register write, only with the reader idle.
  task automatic write_region(input logic [1:0] idx, input int val);
    drain();
    repeat (30) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx[0], 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_START) begin
      shadow_start = val;
      shadow_pos = val;
    end else begin
      shadow_end = val;
    end
  endtask

  task automatic set_region(input int lo, input int hi);
    write_region(REG_END, hi);
    write_region(REG_START, lo);
  endtask

  task automatic test_directed();
    op_word_t w;
    for (int i = 0; i < 9; i++) begin
      w = blank_word(FN_LOAD);
      w.byte_addr = 12'(i);
      w.byte_data = (i == 0) ? 8'h80 : (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'($urandom);
      send_word(w);
    end
    w = blank_word(FN_LOAD); w.byte_addr = 12'hFFF; w.byte_data = 8'hA5; send_word(w);
    w = blank_word(FN_READ); w.width = 0; send_word(w);
    w = blank_word(FN_READ); w.width = 64; send_word(w);
    w = blank_word(FN_READ); w.width = 65; send_word(w);
    w = blank_word(FN_READ); w.width = 127; send_word(w);
    w = blank_word(FN_CLEAR); w.status_bits = 3'b000; send_word(w);
    w = blank_word(FN_UNGET); send_word(w);
    w = blank_word(FN_GET); send_word(w);
    w = blank_word(FN_PEEK); send_word(w);
    w = blank_word(FN_EXPECT); w.expected_bit = 1'b0; send_word(w);
    w = blank_word(FN_EXPECT); w.expected_bit = 1'b1; send_word(w);
    w = blank_word(FN_SKIP); w.skip_count = 16'hFFFF; send_word(w);
    w = blank_word(FN_SEEKA); w.offset = -17'sd32768; send_word(w);
    w = blank_word(FN_SEEKA); w.offset = 17'sd32768; send_word(w);
    for (int d = 0; d < 4; d++) begin
      w = blank_word(FN_SEEKR); w.base_sel = 2'(d);
      w.offset = (d == 2) ? -17'sd70 : 17'sd3;
      send_word(w);
    end
    w = blank_word(FN_CLEAR); w.status_bits = 3'b000; send_word(w);
    w = blank_word(FN_ALIGN); w.width = 0; send_word(w);
    w = blank_word(FN_ALIGN); w.width = 7; send_word(w);
    w = blank_word(FN_SETST); w.status_bits = 3'b111; send_word(w);
    for (int f = 12; f < 16; f++) send_word(blank_word(func_t'(f)));
  endtask

  // Extreme region settings, including a position left beyond the end.
  task automatic test_region_extremes();
    op_word_t w;
    set_region(0, 0);
    for (int i = 0; i < 4; i++) send_word(random_word());
    set_region(32768, 32768);
    for (int i = 0; i < 4; i++) send_word(random_word());
    set_region(32700, 32768);
    for (int i = 0; i < 12; i++) send_word(random_word());
    set_region(0, 32768);
    w = blank_word(FN_SEEKA); w.offset = 17'sd40; send_word(w);
    write_region(REG_END, 20);
    for (int i = 0; i < 8; i++) send_word(random_word());
  endtask

  task automatic test_random(input int n, input int spct, input int rpct);
    send_pct = spct;
    recv_pct = rpct;
    for (int k = 0; k < 3; k++) begin
      set_region($urandom_range(0, 256),
                 ($urandom_range(0, 3) == 0) ? 32768 : 256 + $urandom_range(0, 1024));
      for (int i = 0; i < n / 3; i++) send_word(random_word());
    end
  endtask

  // Long receiver hold-off while words keep coming, then a full pause.
  task automatic test_backpressure();
    send_pct = 0;
    recv_pct = 0;
    hold_requests++;
    for (int i = 0; i < 15; i++) send_word(random_word());
    drain();
    for (int i = 0; i < 15; i++) send_word(random_word());
  endtask

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reader_view_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: result word with none expected: value %h", $time, out_value);
        errors++;
      end else begin
        e = pending_views.pop_front();
        if (out_value !== e.value) begin
          $display("%0t: value expected %h got %h", $time, e.value, out_value);
          errors++;
        end
        if (out_count !== e.count) begin
          $display("%0t: count expected %0d got %0d", $time, e.count, out_count);
          errors++;
        end
        if (out_position !== e.position) begin
          $display("%0t: position expected %0d got %0d", $time, e.position, out_position);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %b got %b", $time, e.status, out_status);
          errors++;
        end
        if (out_good !== e.good) begin
          $display("%0t: good expected %b got %b", $time, e.good, out_good);
          errors++;
        end
        if (out_failed !== e.failed) begin
          $display("%0t: failed expected %b got %b", $time, e.failed, out_failed);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("msb_first_bit_field_reader_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    send_pct = 23;
    recv_pct = 60;
    shadow_start = 0;
    shadow_end = 32768;
    shadow_pos = 0;
    shadow_count = 0;
    shadow_status = 3'b000;
    shadow_value = '0;
    for (int i = 0; i < NUM_BYTES; i++) shadow_written[i] = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FN_QUERY;
    in_width <= '0;
    in_skip_count <= '0;
    in_offset <= '0;
    in_base_sel <= '0;
    in_byte_addr <= '0;
    in_byte_data <= '0;
    in_status_bits <= '0;
    in_expected_bit <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_region_extremes();
    test_random(300, 23, 60);
    test_random(300, 60, 23);
    test_backpressure();
    test_random(150, 0, 0);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("msb_first_bit_field_reader_top: match");
    end else begin
      $display("msb_first_bit_field_reader_top: mismatch");
    end
    $finish;
  end
endmodule
